### rtl/core/gdw_pkg.sv
// Shared types and constants of the grid DDA ray walker.
package gdw_pkg;

    localparam int CELL_W        = 6;
    localparam int VAL_W         = 8;
    localparam int POS_W         = 22;
    localparam int DIST_W        = 32;
    localparam int DIM_CFG_W     = 7;
    localparam int CRD_W         = 9;
    localparam int FRAC_MAX      = 24;
    localparam int GAP_W         = FRAC_MAX + CELL_W + 1;
    localparam int PROD_W        = GAP_W + DIST_W;
    localparam int MAP_DIM_DEF   = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;
    localparam int IN_DATA_W     = 136;
    localparam int OUT_DATA_W    = 80;

    localparam logic [DIM_CFG_W-1:0] DIM_RESET    = 7'd64;
    localparam logic [VAL_W-1:0]     THRESH_RESET = 8'd0;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_THRESH = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MULX,
        B_MULY,
        B_SATY,
        B_STEP,
        B_CHECK,
        B_DONE
    } t_bstate;

    typedef struct packed {
        logic [DIM_CFG_W-1:0] width;
        logic [DIM_CFG_W-1:0] height;
        logic [VAL_W-1:0]     thresh;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [VAL_W-1:0]  val;
        logic [GAP_W-1:0]  gx;
        logic [GAP_W-1:0]  gy;
        logic              nx;
        logic              ny;
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
    } t_work;

    typedef struct packed {
        logic  valid;
        t_work item;
    } t_qhead;

    typedef struct packed {
        logic              hit;
        logic              yside;
        logic [CELL_W-1:0] end_x;
        logic [CELL_W-1:0] end_y;
        logic [DIST_W-1:0] sdx;
        logic [DIST_W-1:0] sdy;
    } t_result;

endpackage

### rtl/core/gdw_front.sv
// Front end: classify incoming items and compute the start gaps of casts.
module gdw_front import gdw_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_valid,
    input  logic                 i_op,
    input  logic [CELL_W-1:0]    i_cx,
    input  logic [CELL_W-1:0]    i_cy,
    input  logic [VAL_W-1:0]     i_val,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic                 i_nx,
    input  logic                 i_ny,
    input  logic [DIST_W-1:0]    i_dx,
    input  logic [DIST_W-1:0]    i_dy,
    input  logic                 i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output t_work                o_item
);

    localparam int SUM_W = GAP_W + 1;

    logic [SUM_W-1:0] hi_x, lo_x, hi_y, lo_y;

    always_comb begin
        if (i_nx) begin
            hi_x = SUM_W'(i_pos_x);
            lo_x = SUM_W'(i_cx) << FRAC_BITS;
        end else begin
            hi_x = (SUM_W'(i_cx) + SUM_W'(1)) << FRAC_BITS;
            lo_x = SUM_W'(i_pos_x);
        end
        if (i_ny) begin
            hi_y = SUM_W'(i_pos_y);
            lo_y = SUM_W'(i_cy) << FRAC_BITS;
        end else begin
            hi_y = (SUM_W'(i_cy) + SUM_W'(1)) << FRAC_BITS;
            lo_y = SUM_W'(i_pos_y);
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item     = '0;
        o_item.op  = t_op'(i_op);
        o_item.cx  = i_cx;
        o_item.cy  = i_cy;
        o_item.val = i_val;
        o_item.nx  = i_nx;
        o_item.ny  = i_ny;
        o_item.dx  = i_dx;
        o_item.dy  = i_dy;
        // clamp a negative gap to zero
        o_item.gx  = (hi_x > lo_x) ? GAP_W'(hi_x - lo_x) : '0;
        o_item.gy  = (hi_y > lo_y) ? GAP_W'(hi_y - lo_y) : '0;
    end

endmodule

### rtl/core/gdw_queue.sv
// Two-entry queue between front end and walker.
module gdw_queue import gdw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_work  i_item,
    input  logic   i_pop,
    output logic   o_full,
    output t_qhead o_head
);

    t_work       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        n_wp, n_rp;
    logic [1:0]  n_cnt;
    logic        do_pop;

    assign o_full = (r_cnt == 2'd2);
    assign do_pop = i_pop && (r_cnt != 2'd0);
    assign o_head = '{valid: (r_cnt != 2'd0), item: r_mem[r_rp]};

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = !r_wp;
        end
        if (do_pop) begin
            n_rp = !r_rp;
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### rtl/core/gdw_walker.sv
// Back end: map store, side distance setup and cell-by-cell walk.
module gdw_walker import gdw_pkg::*; #(
    parameter int MAP_DIM   = MAP_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_qhead  i_head,
    output logic    o_pop,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    localparam int AXW   = $clog2(MAP_DIM);
    localparam int EW    = AXW + DIM_CFG_W;
    localparam int DEPTH = 1 << (2 * AXW);

    logic [VAL_W-1:0] r_map [DEPTH];
    logic [VAL_W-1:0] r_rd;

    t_bstate                  r_state, n_state;
    logic signed [CRD_W-1:0]  r_x, r_y, n_x, n_y;
    logic [DIST_W-1:0]        r_sx, r_sy, n_sx, n_sy;
    logic [DIST_W-1:0]        r_dx, r_dy, n_dx, n_dy;
    logic [GAP_W-1:0]         r_gx, r_gy, n_gx, n_gy;
    logic                     r_nx, r_ny, n_nx, n_ny;
    logic                     r_side, n_side;
    logic                     r_hit, n_hit;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic                     r_ov, n_ov;
    t_result                  r_res, n_res;

    logic [GAP_W-1:0]         mul_a;
    logic [DIST_W-1:0]        mul_b;
    logic [PROD_W-1:0]        prod_sh;
    logic [DIST_W-1:0]        prod_sat;
    logic [DIST_W:0]          sum_x, sum_y;
    logic [DIST_W-1:0]        add_x, add_y;
    logic [DIM_CFG_W-1:0]     wlim, hlim;
    logic signed [CRD_W-1:0]  wlim_s, hlim_s;
    logic                     leave;
    logic                     wr_en;
    logic [EW-1:0]            wx_e, wy_e, rx_e, ry_e;
    logic [2*AXW-1:0]         wr_addr, rd_addr;

    assign mul_a    = (r_state == B_MULY) ? r_gy : r_gx;
    assign mul_b    = (r_state == B_MULY) ? r_dy : r_dx;
    assign prod_sh  = r_prod >> FRAC_BITS;
    assign prod_sat = (prod_sh[PROD_W-1:DIST_W] != '0) ? '1 : prod_sh[DIST_W-1:0];

    assign sum_x = {1'b0, r_sx} + {1'b0, r_dx};
    assign sum_y = {1'b0, r_sy} + {1'b0, r_dy};
    assign add_x = sum_x[DIST_W] ? '1 : sum_x[DIST_W-1:0];
    assign add_y = sum_y[DIST_W] ? '1 : sum_y[DIST_W-1:0];

    assign wlim   = (32'(i_cfg.width) > 32'(MAP_DIM)) ? DIM_CFG_W'(MAP_DIM) : i_cfg.width;
    assign hlim   = (32'(i_cfg.height) > 32'(MAP_DIM)) ? DIM_CFG_W'(MAP_DIM) : i_cfg.height;
    assign wlim_s = $signed(CRD_W'(wlim));
    assign hlim_s = $signed(CRD_W'(hlim));
    assign leave  = (r_y <= 0) || (r_x <= 0) || (r_y >= hlim_s) ||
                    (r_x >= wlim_s - CRD_W'(1));

    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_gx    = r_gx;
        n_gy    = r_gy;
        n_nx    = r_nx;
        n_ny    = r_ny;
        n_side  = r_side;
        n_hit   = r_hit;
        n_prod  = r_prod;
        n_ov    = r_ov && !i_ready;
        n_res   = r_res;
        o_pop   = 1'b0;
        wr_en   = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.item.op == OP_WRITE) begin
                        wr_en = (32'(i_head.item.cx) < 32'(MAP_DIM)) &&
                                (32'(i_head.item.cy) < 32'(MAP_DIM));
                    end else begin
                        n_x     = $signed(CRD_W'(i_head.item.cx));
                        n_y     = $signed(CRD_W'(i_head.item.cy));
                        n_gx    = i_head.item.gx;
                        n_gy    = i_head.item.gy;
                        n_dx    = i_head.item.dx;
                        n_dy    = i_head.item.dy;
                        n_nx    = i_head.item.nx;
                        n_ny    = i_head.item.ny;
                        n_state = B_MULX;
                    end
                end
            end
            B_MULX: begin
                n_prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
                n_state = B_MULY;
            end
            B_MULY: begin
                n_sx    = prod_sat;
                n_prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
                n_state = B_SATY;
            end
            B_SATY: begin
                n_sy    = prod_sat;
                n_state = B_STEP;
            end
            B_STEP, B_CHECK: begin
                if (r_state == B_CHECK && leave) begin
                    n_hit   = 1'b0;
                    n_state = B_DONE;
                end else if (r_state == B_CHECK && r_rd > i_cfg.thresh) begin
                    n_hit   = 1'b1;
                    n_state = B_DONE;
                end else begin
                    // advance along the axis with the smaller side distance
                    if (r_sx < r_sy) begin
                        n_sx   = add_x;
                        n_x    = r_nx ? r_x - CRD_W'(1) : r_x + CRD_W'(1);
                        n_side = 1'b0;
                    end else begin
                        n_sy   = add_y;
                        n_y    = r_ny ? r_y - CRD_W'(1) : r_y + CRD_W'(1);
                        n_side = 1'b1;
                    end
                    n_state = B_CHECK;
                end
            end
            B_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov        = 1'b1;
                    n_res.hit   = r_hit;
                    n_res.yside = r_side;
                    n_res.end_x = r_x[CELL_W-1:0];
                    n_res.end_y = r_y[CELL_W-1:0];
                    n_res.sdx   = r_sx;
                    n_res.sdy   = r_sy;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign wx_e    = EW'(i_head.item.cx);
    assign wy_e    = EW'(i_head.item.cy);
    assign rx_e    = EW'(n_x[DIM_CFG_W-1:0]);
    assign ry_e    = EW'(n_y[DIM_CFG_W-1:0]);
    assign wr_addr = {wy_e[AXW-1:0], wx_e[AXW-1:0]};
    assign rd_addr = {ry_e[AXW-1:0], rx_e[AXW-1:0]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= i_head.item.val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_map[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_gx   <= n_gx;
        r_gy   <= n_gy;
        r_nx   <= n_nx;
        r_ny   <= n_ny;
        r_side <= n_side;
        r_hit  <= n_hit;
        r_prod <= n_prod;
        r_res  <= n_res;
    end

`ifndef NO_ASSERTIONS
    a_one_axis_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CHECK && n_state == B_CHECK) |=> ($stable(r_x) != $stable(r_y)))
        else $error("walk step must move exactly one coordinate");

    a_side_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CHECK && $past(r_state) == B_CHECK) |->
        (r_sx >= $past(r_sx) && r_sy >= $past(r_sy)))
        else $error("side distance decreased during walk");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DONE && r_ov && !i_ready) |=> (r_state == B_DONE && r_ov))
        else $error("result overwritten while output still pending");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.item.op == OP_CAST) |=> (r_state == B_MULX))
        else $error("cast popped without entering setup");
`endif

endmodule

### rtl/core/grid_dda_ray_walker_top.sv
// Top level of the grid DDA ray walker: ports, config registers, front, queue, walker.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: cast/write fields, tuser: operation
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: walk result
//  cfg       in   i_cfg_we                       i_cfg_addr, i_cfg_wdata
//
//  A write item is popped in the idle state. A cast passes the states MULX, MULY, SATY and STEP,
//  then CHECK once per walked cell (at most width + height cells), then DONE until the output is free.
//  The two-entry queue accepts new items until it is full, also while the walker runs or a result waits.
//  Reset is synchronous; the map store holds no reset value.
module grid_dda_ray_walker_top import gdw_pkg::*; #(
    parameter int MAP_DIM   = MAP_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cell_x, cell_y, cell_value, pos_x, pos_y, dir_x_negative, dir_y_negative,
    // delta_x, delta_y, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // wall_hit, hit_on_y_side, end_x, end_y, final x distance, final y distance, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    q_full;
    logic    q_push;
    logic    q_pop;
    t_work   q_item;
    t_qhead  q_head;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= DIM_RESET;
            r_cfg.height <= DIM_RESET;
            r_cfg.thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_wdata[DIM_CFG_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_wdata[DIM_CFG_W-1:0];
                CFG_THRESH: r_cfg.thresh <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    gdw_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser),
        .i_cx     (s_axis_tdata[5:0]),
        .i_cy     (s_axis_tdata[11:6]),
        .i_val    (s_axis_tdata[19:12]),
        .i_pos_x  (s_axis_tdata[41:20]),
        .i_pos_y  (s_axis_tdata[63:42]),
        .i_nx     (s_axis_tdata[64]),
        .i_ny     (s_axis_tdata[65]),
        .i_dx     (s_axis_tdata[97:66]),
        .i_dy     (s_axis_tdata[129:98]),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (q_push),
        .o_item   (q_item)
    );

    gdw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    gdw_walker #(
        .MAP_DIM   (MAP_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (res)
    );

    assign m_axis_tdata = {2'b00, res.sdy, res.sdx, res.end_y, res.end_x, res.yside, res.hit};

endmodule

### tb/tb_top.sv
// Testbench of the grid DDA ray walker: map loads, directed and random ray casts.
`timescale 1ns / 100ps

module tb_top;
    import gdw_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 120;
    localparam int FILL_DIM     = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [DIST_W-1:0]    ONE_Q16   = 32'h0001_0000;
    localparam logic [VAL_W-1:0]     RING_CODE = 8'hFF;

    typedef struct packed {
        t_op               op;
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [VAL_W-1:0]  val;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic              nx;
        logic              ny;
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
    } t_ray_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // cell_x, cell_y, cell_value, pos_x, pos_y, dir_x_negative, dir_y_negative,
    // delta_x, delta_y, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // operation
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // wall_hit, hit_on_y_side, end_x, end_y, final x distance, final y distance, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    logic [VAL_W-1:0]     grid_codes [MAP_DIM_DEF*MAP_DIM_DEF];
    logic [DIM_CFG_W-1:0] width_reg  = DIM_RESET;
    logic [DIM_CFG_W-1:0] height_reg = DIM_RESET;
    logic [VAL_W-1:0]     thresh_reg = THRESH_RESET;
    t_result              walk_results_due [$];
    t_result              due_result;
    int                   mismatches = 0;
    int                   cycle_count = 0;
    int                   start_span = FILL_DIM - 2;
    bit                   no_idle = 1'b0;

    grid_dda_ray_walker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run timed out", $time);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 17);
    end

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a, b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? '1 : s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] start_side(input logic [POS_W-1:0] pos,
                                                     input logic [CELL_W-1:0] idx,
                                                     input logic neg,
                                                     input logic [DIST_W-1:0] delta);
        logic [63:0] hi, lo, gap, prod;
        if (neg) begin
            hi = 64'(pos);
            lo = 64'(idx) << FRAC_BITS_DEF;
        end else begin
            hi = (64'(idx) + 64'd1) << FRAC_BITS_DEF;
            lo = 64'(pos);
        end
        gap  = (hi > lo) ? hi - lo : 64'd0;
        prod = (gap * 64'(delta)) >> FRAC_BITS_DEF;
        return (prod > 64'hFFFF_FFFF) ? '1 : prod[DIST_W-1:0];
    endfunction

    function automatic t_result cast_ray(input t_ray_item it);
        t_result           r;
        int                x, y, wlim, hlim, sx_step, sy_step;
        logic [DIST_W-1:0] sx, sy;
        logic              side, hit, done;
        sx = start_side(it.px, it.cx, it.nx, it.dx);
        sy = start_side(it.py, it.cy, it.ny, it.dy);
        sx_step = it.nx ? -1 : 1;
        sy_step = it.ny ? -1 : 1;
        x = int'(it.cx);
        y = int'(it.cy);
        wlim = (width_reg > MAP_DIM_DEF) ? MAP_DIM_DEF : int'(width_reg);
        hlim = (height_reg > MAP_DIM_DEF) ? MAP_DIM_DEF : int'(height_reg);
        side = 1'b0;
        hit = 1'b0;
        done = 1'b0;
        while (!done) begin
            if (sx < sy) begin
                sx = sat_add(sx, it.dx);
                x += sx_step;
                side = 1'b0;
            end else begin
                sy = sat_add(sy, it.dy);
                y += sy_step;
                side = 1'b1;
            end
            if (y <= 0 || x <= 0 || y >= hlim || x >= wlim - 1) begin
                done = 1'b1;
            end else if (grid_codes[y * MAP_DIM_DEF + x] > thresh_reg) begin
                hit = 1'b1;
                done = 1'b1;
            end
        end
        r.hit   = hit;
        r.yside = side;
        r.end_x = x[CELL_W-1:0];
        r.end_y = y[CELL_W-1:0];
        r.sdx   = sx;
        r.sdy   = sy;
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(input t_ray_item it);
        return {6'b0, it.dy, it.dx, it.ny, it.nx, it.py, it.px, it.val, it.cy, it.cx};
    endfunction

    function automatic t_ray_item cast_item(input logic [CELL_W-1:0] cx, cy,
                                            input logic [POS_W-1:0] px, py,
                                            input logic nx, ny,
                                            input logic [DIST_W-1:0] dx, dy);
        t_ray_item it;
        it.op = OP_CAST;
        it.cx = cx;
        it.cy = cy;
        it.val = VAL_W'($urandom);
        it.px = px;
        it.py = py;
        it.nx = nx;
        it.ny = ny;
        it.dx = dx;
        it.dy = dy;
        return it;
    endfunction

    function automatic t_ray_item write_item(input logic [CELL_W-1:0] cx, cy,
                                             input logic [VAL_W-1:0] val);
        t_ray_item it;
        it = cast_item(cx, cy, POS_W'($urandom), POS_W'($urandom), 1'($urandom),
                       1'($urandom), $urandom, $urandom);
        it.op = OP_WRITE;
        it.val = val;
        return it;
    endfunction

    function automatic bit on_ring(input logic [CELL_W-1:0] cx, cy);
        return (int'(cx) == FILL_DIM - 1 && int'(cy) < FILL_DIM) ||
               (int'(cy) == FILL_DIM - 1 && int'(cx) < FILL_DIM);
    endfunction

    function automatic int eff_dim(input logic [CFG_DATA_W-1:0] v);
        int d;
        d = int'(v[DIM_CFG_W-1:0]);
        return (d > MAP_DIM_DEF) ? MAP_DIM_DEF : d;
    endfunction

    function automatic logic [VAL_W-1:0] random_code();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return 8'd0;
            7: return 8'hFF;
            default: return VAL_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] random_delta();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(32'h0001_0000, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] random_pos(input logic [CELL_W-1:0] idx);
        if ($urandom_range(0, 99) < 15)
            return POS_W'($urandom);
        return {idx, 16'($urandom)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'hFF;
            3: return 8'd65;
            4: return 8'd64;
            default: return CFG_DATA_W'($urandom_range(2, 64));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] random_thresh();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'hFF;
            default: return VAL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_ray_item random_item();
        logic [CELL_W-1:0] cx, cy;
        logic [VAL_W-1:0]  code;
        if ($urandom_range(0, 3) == 0) begin
            cx = CELL_W'($urandom);
            cy = CELL_W'($urandom);
            code = on_ring(cx, cy) ? RING_CODE : random_code();
            return write_item(cx, cy, code);
        end
        cx = CELL_W'($urandom_range(0, start_span));
        cy = CELL_W'($urandom_range(0, start_span));
        return cast_item(cx, cy, random_pos(cx), random_pos(cy), 1'($urandom),
                         1'($urandom), random_delta(), random_delta());
    endfunction

    task automatic check_field(input string name, input logic [DIST_W-1:0] want, got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (walk_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                due_result = walk_results_due.pop_front();
                check_field("wall_hit", due_result.hit, m_axis_tdata[0]);
                check_field("hit_on_y_side", due_result.yside, m_axis_tdata[1]);
                check_field("end_x", due_result.end_x, m_axis_tdata[7:2]);
                check_field("end_y", due_result.end_y, m_axis_tdata[13:8]);
                check_field("x_distance", due_result.sdx, m_axis_tdata[45:14]);
                check_field("y_distance", due_result.sdy, m_axis_tdata[77:46]);
            end
        end
    end

    task automatic send_item(input t_ray_item it);
        while (!no_idle && $urandom_range(0, 99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (it.op == OP_WRITE)
            grid_codes[int'(it.cy) * MAP_DIM_DEF + int'(it.cx)] = it.val;
        else
            walk_results_due.push_back(cast_ray(it));
    endtask

    // Drop valid, wait for every result due, then let the walker go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (walk_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] w, h, t);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_THRESH;
        i_cfg_wdata <= t;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SPARE;
        i_cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_reg  = w[DIM_CFG_W-1:0];
        height_reg = h[DIM_CFG_W-1:0];
        thresh_reg = t;
    endtask

    // Fill the corner region, closed by a ring of walls on its far row and column.
    task automatic test_map_fill();
        for (int y = 0; y < FILL_DIM; y++)
            for (int x = 0; x < FILL_DIM; x++)
                send_item(write_item(CELL_W'(x), CELL_W'(y),
                                     on_ring(CELL_W'(x), CELL_W'(y)) ? RING_CODE
                                                                     : random_code()));
    endtask

    task automatic test_directed_casts();
        send_item(write_item(6'd63, 6'd63, 8'hFF));
        send_item(write_item(6'd0, 6'd0, 8'h00));
        send_item(cast_item(6'd0, 6'd0, '0, '0, 1'b0, 1'b0, ONE_Q16, ONE_Q16));
        send_item(cast_item(6'd63, 6'd63, '1, '1, 1'b1, 1'b1, '1, '1));
        send_item(cast_item(6'd11, 6'd11, {6'd11, 16'h8000}, {6'd11, 16'h8000},
                            1'b0, 1'b1, '0, '0));
        send_item(cast_item(6'd11, 6'd11, {6'd11, 16'h4000}, {6'd11, 16'hC000},
                            1'b1, 1'b0, 32'h0001_4000, 32'h0000_4000));
        // start gap below zero on the x axis
        send_item(cast_item(6'd20, 6'd10, {6'd5, 16'h0}, {6'd10, 16'h0},
                            1'b1, 1'b0, ONE_Q16, ONE_Q16));
        send_item(cast_item(6'd5, 6'd20, {6'd40, 16'h0}, {6'd20, 16'h1},
                            1'b0, 1'b0, ONE_Q16, 32'h0001_4000));
        // saturated side distances
        send_item(cast_item(6'd0, 6'd63, '0, '1, 1'b0, 1'b1, '1, ONE_Q16));
        send_item(cast_item(6'd20, 6'd20, 22'h2AAAAA, 22'h155555, 1'b1, 1'b1,
                            32'hAAAA_AAAA, 32'h5555_5555));
        send_item(cast_item(6'd20, 6'd20, 22'h155555, 22'h2AAAAA, 1'b0, 1'b0,
                            32'h5555_5555, 32'hAAAA_AAAA));
        // equal side distances step along y
        send_item(cast_item(6'd10, 6'd20, {6'd10, 16'h8000}, {6'd20, 16'h8000},
                            1'b0, 1'b1, ONE_Q16, ONE_Q16));
    endtask

    task automatic test_config_extremes();
        settle();
        set_config(8'd0, 8'd64, 8'd0);
        send_item(cast_item(6'd30, 6'd30, {6'd30, 16'h8000}, {6'd30, 16'h8000},
                            1'b1, 1'b0, ONE_Q16, 32'h0002_0000));
        settle();
        set_config(8'd64, 8'd0, 8'd0);
        send_item(cast_item(6'd30, 6'd30, {6'd30, 16'h8000}, {6'd30, 16'h8000},
                            1'b0, 1'b0, 32'h0002_0000, ONE_Q16));
        settle();
        set_config(8'hFF, 8'hFF, 8'hFE);
        send_item(cast_item(6'd1, 6'd1, {6'd1, 16'h2000}, {6'd1, 16'h9000},
                            1'b0, 1'b0, 32'h0001_4000, ONE_Q16));
        send_item(cast_item(6'd22, 6'd22, {6'd22, 16'h2000}, {6'd22, 16'h9000},
                            1'b1, 1'b1, ONE_Q16, 32'h0001_4000));
        settle();
        set_config(8'd1, 8'd1, 8'd128);
        send_item(cast_item(6'd0, 6'd0, '0, '0, 1'b0, 1'b0, ONE_Q16, ONE_Q16));
        settle();
        set_config(8'd65, 8'd2, 8'd0);
        send_item(cast_item(6'd10, 6'd1, {6'd10, 16'h0}, {6'd1, 16'h8000},
                            1'b0, 1'b0, 32'h0000_4000, 32'h0040_0000));
    endtask

    task automatic test_random_walks();
        logic [CFG_DATA_W-1:0] w, h, t;
        for (int phase = 0; phase < 8; phase++) begin
            w = (phase == 0 || phase == 7) ? 8'd64 : random_dim();
            h = (phase == 0 || phase == 7) ? 8'd64 : random_dim();
            t = random_thresh();
            // keep walks inside the filled region on a large map
            if (eff_dim(w) > FILL_DIM || eff_dim(h) > FILL_DIM) begin
                if (t == RING_CODE)
                    t = RING_CODE - 8'd1;
                start_span = FILL_DIM - 2;
            end else begin
                start_span = MAP_DIM_DEF - 1;
            end
            settle();
            set_config(w, h, t);
            no_idle = (phase == 5);
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_map_fill();
        test_directed_casts();
        test_config_extremes();
        test_random_walks();
        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
